// File: rtl/quadratic_probe_hash_table_top_macros.svh
// Assertion macros for the hash table block.
`ifndef QUADRATIC_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define QPH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qph: assertion failed");
`define QPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qph: assertion failed");
`else
`define QPH_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define QPH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/qph_pkg.sv
package qph_pkg;

  localparam int SIZE_W    = 11;
  localparam int KEY_W     = 31;
  localparam int KEY_BIT_W = $clog2(KEY_W);
  localparam int SLOT_W    = 10;
  localparam int CNT_W     = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = {SIZE_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_SAT    = {CNT_W{1'b1}};

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_PRD,
    S_PCHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  insert_collisions;
    logic [CNT_W-1:0]  search_collisions;
  } out_item_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/quadratic_probe_hash_table_top.sv
// Open-addressing hash table with quadratic probing.
// Input channel (in_valid/in_ready, in_data): one item is an insert or a
// search of a 31-bit key. Output channel (out_valid/out_ready, out_data):
// one result item per input item, in order, with status, slot and both
// collision counters as they stand after that item.
// Config channel (cfg_valid/cfg_ready, cfg_data): table_size, always ready;
// write it only while the block is idle. 0 acts as 1, above TABLE_DEPTH
// acts as TABLE_DEPTH.
// Sequence: accept, then the home slot (key mod size, one key bit per
// cycle through the shared compare-subtract unit), a read of the home
// slot, then the probes in turn, then a load into the output register.
// One item is in work at a time.
// Reset: synchronous; after it a clearing pass writes every RAM entry empty,
// during which no item is accepted.
// A stalled receiver leaves the result in the output register; the next
// item is still taken and waits for that register before it finishes.
`include "quadratic_probe_hash_table_top_macros.svh"

module quadratic_probe_hash_table_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  qph_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output qph_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [qph_pkg::SIZE_W-1:0] cfg_data
);
  import qph_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  // largest usable size: bounded by the store and by the register width
  localparam int CAP = (TABLE_DEPTH < int'(SIZE_MAX)) ? TABLE_DEPTH : int'(SIZE_MAX);

  state_t state, state_next;

  logic [SIZE_W-1:0]    table_size;
  logic [SIZE_W-1:0]    n_cur;
  logic [SIZE_W-1:0]    n_r;
  logic                 kind_r;
  logic [KEY_W-1:0]     key_r;
  logic [KEY_BIT_W-1:0] bit_cnt;
  logic [SIZE_W-1:0]    pos;       // remainder while dividing, probe slot after
  logic [SIZE_W-1:0]    d;         // (2i+1) mod n, step to the next probe
  logic [SIZE_W-1:0]    probe_idx;
  logic [AW-1:0]        clr_cnt;
  logic [CNT_W-1:0]     ins_cnt;
  logic [CNT_W-1:0]     srch_cnt;
  status_t              res_status;
  logic [SLOT_W-1:0]    res_slot;

  // shared unit
  logic [SIZE_W:0]   csub_a;
  logic [SIZE_W-1:0] pos_step;

  // RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd;

  // probe decision
  logic            is_search;
  logic            hit;
  logic            last_probe;
  logic            probe_end;
  logic            collide;
  status_t         outcome;
  logic [SIZE_W:0] d_plus;
  logic [SIZE_W:0] d_once;
  logic [SIZE_W-1:0] d_next;
  logic            out_load;

  // effective size
  always_comb begin
    if (table_size == '0) begin
      n_cur = SIZE_W'(1);
    end else if (table_size > SIZE_W'(CAP)) begin
      n_cur = SIZE_W'(CAP);
    end else begin
      n_cur = table_size;
    end
  end

  qph_csub u_csub (
    .a (csub_a),
    .n (n_r),
    .y (pos_step)
  );

  qph_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd        = entry_t'(ram_rdata);
  assign is_search = (kind_r == KIND_SEARCH);
  assign hit       = rd.used && (rd.key == key_r);
  assign last_probe = (probe_idx == n_r - SIZE_W'(1));
  assign probe_end = !rd.used || (is_search && hit) || last_probe;
  // home slot taken by something that does not settle the item
  assign collide   = (probe_idx == '0) && rd.used && !(is_search && hit);
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (!rd.used) begin
      outcome = is_search ? ST_NOT_FOUND : ST_INSERTED;
    end else if (is_search && hit) begin
      outcome = ST_FOUND;
    end else begin
      outcome = is_search ? ST_NOT_FOUND : ST_FULL;
    end
  end

  // d + 2 mod n; a second subtract only matters when n is 1
  always_comb begin
    d_plus = {1'b0, d} + (SIZE_W+1)'(2);
    d_once = (d_plus >= {1'b0, n_r}) ? d_plus - {1'b0, n_r} : d_plus;
    d_next = (d_once >= {1'b0, n_r}) ? SIZE_W'(d_once - {1'b0, n_r})
                                     : d_once[SIZE_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == AW'(TABLE_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DIV;
      end
      S_DIV: begin
        if (bit_cnt == '0) state_next = S_PRD;
      end
      S_PRD: begin
        state_next = S_PCHK;
      end
      S_PCHK: begin
        if (probe_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(pos);
    ram_wdata = '{used: 1'b1, key: key_r};
    ram_raddr = AW'(pos);
    csub_a    = {1'b0, pos} + {1'b0, d};
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_DIV: begin
        csub_a = {pos, key_r[bit_cnt]};
      end
      S_PRD: begin
        ram_raddr = AW'(pos);
      end
      S_PCHK: begin
        ram_raddr = AW'(pos_step);
        ram_we    = !rd.used && !is_search;
      end
      S_DONE: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      table_size <= SIZE_RESET;
      clr_cnt    <= '0;
      ins_cnt    <= '0;
      srch_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        table_size <= cfg_data;
      end
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (in_valid && in_ready) begin
        kind_r    <= in_data.kind;
        key_r     <= in_data.key;
        n_r       <= n_cur;
        pos       <= '0;
        bit_cnt   <= KEY_BIT_W'(KEY_W - 1);
        probe_idx <= '0;
        d         <= (n_cur == SIZE_W'(1)) ? '0 : SIZE_W'(1);
      end
      if (state == S_DIV) begin
        pos     <= pos_step;
        bit_cnt <= bit_cnt - KEY_BIT_W'(1);
      end
      if (state == S_PCHK) begin
        if (collide && !is_search && ins_cnt != CNT_SAT) ins_cnt <= ins_cnt + CNT_W'(1);
        if (collide && is_search && srch_cnt != CNT_SAT) srch_cnt <= srch_cnt + CNT_W'(1);
        if (probe_end) begin
          res_status <= outcome;
          res_slot   <= (outcome == ST_INSERTED || outcome == ST_FOUND) ?
                        pos[SLOT_W-1:0] : '0;
        end else begin
          pos       <= pos_step;
          d         <= d_next;
          probe_idx <= probe_idx + SIZE_W'(1);
        end
      end
      // a new result takes over in the cycle the old one leaves
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register: payload, no reset
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= '{status: res_status, slot: res_slot,
                    insert_collisions: ins_cnt, search_collisions: srch_cnt};
    end
  end

  // remainder and probe slot stay inside the active size
  `QPH_ASSERT_IMPLY(a_pos_in_range, clk, rst, (state == S_DIV || state == S_PCHK), (pos < n_r))
  // probing never runs past size probes
  `QPH_ASSERT_IMPLY(a_probe_bound, clk, rst, (state == S_PCHK), (probe_idx < n_r))
  // collision counters never go backwards
  `QPH_ASSERT_NEXT(a_ins_mono, clk, rst, !rst, (ins_cnt >= $past(ins_cnt)))
  `QPH_ASSERT_NEXT(a_srch_mono, clk, rst, !rst, (srch_cnt >= $past(srch_cnt)))

endmodule

// File: rtl/qph_ram.sv
module qph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/qph_csub.sv
// Compare and subtract: y = (a >= n) ? a - n : a, for a < 2n.
module qph_csub (
  input  logic [qph_pkg::SIZE_W:0]   a,
  input  logic [qph_pkg::SIZE_W-1:0] n,
  output logic [qph_pkg::SIZE_W-1:0] y
);
  import qph_pkg::*;

  logic [SIZE_W:0] diff;

  always_comb begin
    diff = a - {1'b0, n};
    y    = (a >= {1'b0, n}) ? diff[SIZE_W-1:0] : a[SIZE_W-1:0];
  end

endmodule
